// ----- rtl/knn_pkg.sv -----
package knn_pkg;

    localparam int DIST_BITS  = 32;
    localparam int WEIGHT_BITS = 32;
    localparam int COUNT_BITS = 8;

    typedef enum logic [1:0] {
        WMODE_EQUAL  = 2'd0,
        WMODE_INV    = 2'd1,
        WMODE_INV_SQ = 2'd2
    } wmode_t;

    localparam logic [0:0] REG_WEIGHT_MODE = 1'b0;
    localparam logic [0:0] REG_USE_COUNT   = 1'b1;

    typedef enum logic [0:0] {
        ITEM_LOAD     = 1'b0,
        ITEM_NEIGHBOR = 1'b1
    } item_kind_t;

    // item handed from front to back
    typedef struct packed {
        logic                  axis;
        logic                  good;
        logic                  last;
        logic                  zero_dist;
        logic                  squared;
        logic [DIST_BITS-1:0]  distance;
    } nb_item_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_RECIP,
        BK_MUL,
        BK_ACC,
        BK_DIV,
        BK_OUT
    } back_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

endpackage

// ----- rtl/knn_ram.sv -----
module knn_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

// ----- rtl/knn_divider.sv -----
// unsigned restoring divider, one quotient bit per cycle
module knn_divider #(
    parameter int N_BITS = 64,
    parameter int D_BITS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [N_BITS-1:0] numer,
    input  logic [D_BITS-1:0] denom,
    output logic              done,
    output logic [N_BITS-1:0] quot
);
    localparam int CNT_BITS = $clog2(N_BITS + 1);

    knn_pkg::div_state_t state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [N_BITS-1:0]   q_reg, q_next;
    logic [D_BITS:0]     r_reg, r_next;
    logic [D_BITS-1:0]   d_reg, d_next;
    logic [D_BITS:0]     trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= knn_pkg::DIV_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        d_next     = d_reg;
        trial      = {r_reg[D_BITS-1:0], q_reg[N_BITS-1]};
        case (state_reg)
            knn_pkg::DIV_IDLE: begin
                if (start) begin
                    q_next     = numer;
                    r_next     = '0;
                    d_next     = denom;
                    cnt_next   = CNT_BITS'(N_BITS);
                    state_next = knn_pkg::DIV_RUN;
                end
            end
            knn_pkg::DIV_RUN: begin
                if (trial >= {1'b0, d_reg}) begin
                    r_next = trial - {1'b0, d_reg};
                    q_next = {q_reg[N_BITS-2:0], 1'b1};
                end else begin
                    r_next = trial;
                    q_next = {q_reg[N_BITS-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1)) begin
                    state_next = knn_pkg::DIV_DONE;
                end
            end
            knn_pkg::DIV_DONE: begin
                state_next = knn_pkg::DIV_IDLE;
            end
            default: state_next = knn_pkg::DIV_IDLE;
        endcase
    end

    assign done = (state_reg == knn_pkg::DIV_DONE);
    assign quot = q_reg;
endmodule

// ----- rtl/knn_front.sv -----
// accepts items, writes the table on loads and forwards neighbours to the queue
module knn_front #(
    parameter int TABLE_DEPTH   = 4096,
    parameter int POSITION_BITS = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             mode,
    input  logic                             axis,
    input  logic [11:0]                      entry_index,
    input  logic signed [31:0]               position_value,
    input  logic                             position_missing,
    input  logic [31:0]                      neighbour_distance,
    input  logic                             last_neighbour,
    input  logic [1:0]                       weight_mode,
    output logic                             ram_wr_en,
    output logic [$clog2(2*TABLE_DEPTH)-1:0] ram_wr_addr,
    output logic [POSITION_BITS:0]           ram_wr_data,
    output logic                             q_push,
    output knn_pkg::nb_item_t                q_item,
    output logic [$clog2(2*TABLE_DEPTH)-1:0] q_addr,
    input  logic                             q_full,
    input  logic                             q_empty
);
    localparam int AW = $clog2(2*TABLE_DEPTH);
    localparam int EW = $clog2(TABLE_DEPTH);
    localparam int IW = ((EW > 12) ? EW : 12) + 1;
    localparam logic signed [47:0] PMAX = (48'sd1 <<< (POSITION_BITS-1)) - 48'sd1;
    localparam logic signed [47:0] PMIN = -PMAX - 48'sd1;

    logic              in_range;
    logic signed [47:0] v_ext, v_sat;
    logic [AW-1:0]     slot;

    // a load waits until no queued neighbour can still read the old entry
    assign s_ready  = !q_full && ((mode == knn_pkg::ITEM_NEIGHBOR) || q_empty);
    assign in_range = IW'(entry_index) < IW'(TABLE_DEPTH);
    assign slot     = AW'({axis, EW'(entry_index)});
    assign v_ext    = 48'(position_value);

    always_comb begin
        if (v_ext > PMAX) v_sat = PMAX;
        else if (v_ext < PMIN) v_sat = PMIN;
        else v_sat = v_ext;
    end

    assign ram_wr_en   = s_valid && s_ready && (mode == knn_pkg::ITEM_LOAD) && in_range;
    assign ram_wr_addr = slot;
    assign ram_wr_data = {position_missing, v_sat[POSITION_BITS-1:0]};

    assign q_push           = s_valid && s_ready && (mode == knn_pkg::ITEM_NEIGHBOR);
    assign q_addr           = slot;
    assign q_item.axis      = axis;
    assign q_item.good      = in_range;
    assign q_item.last      = last_neighbour;
    assign q_item.zero_dist = (neighbour_distance == '0);
    assign q_item.squared   = (weight_mode == knn_pkg::WMODE_INV_SQ);
    assign q_item.distance  = neighbour_distance;
endmodule

// ----- rtl/knn_queue.sv -----
// small fifo between front and back
module knn_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] buf_reg [DEPTH];
    logic [PW-1:0]    wp_reg, rp_reg;
    logic [PW:0]      cnt_reg;

    assign full     = (cnt_reg == (PW+1)'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = buf_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
        if (push) buf_reg[wp_reg] <= push_data;
    end
endmodule

// ----- rtl/knn_back.sv -----
// reads the table, forms the weight, accumulates and finishes each event
module knn_back #(
    parameter int TABLE_DEPTH   = 4096,
    parameter int POSITION_BITS = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_empty,
    input  knn_pkg::nb_item_t                q_item,
    input  logic [$clog2(2*TABLE_DEPTH)-1:0] q_addr,
    output logic                             q_pop,
    output logic [$clog2(2*TABLE_DEPTH)-1:0] ram_rd_addr,
    input  logic [POSITION_BITS:0]           ram_rd_data,
    input  logic [1:0]                       weight_mode,
    input  logic [7:0]                       use_count,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_axis,
    output logic signed [31:0]               m_coordinate,
    output logic                             m_ok,
    output logic [7:0]                       m_good
);
    localparam logic signed [63:0] S64MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64MIN = 64'sh8000_0000_0000_0000;

    knn_pkg::back_state_t state_reg, state_next;
    knn_pkg::nb_item_t    item_reg, item_next;

    logic signed [63:0] wsum_reg, wsum_next;
    logic [47:0]        wtot_reg, wtot_next;
    logic signed [47:0] psum_reg, psum_next;
    logic [7:0]         cnt_reg, cnt_next;
    logic               zseen_reg, zseen_next;
    logic               done_reg, done_next;
    logic               use_reg, use_next;
    logic signed [63:0] val_reg, val_next;
    logic [31:0]        w_reg, w_next;
    logic signed [63:0] prod_reg, prod_next;
    logic               dsq_reg, dsq_next;
    logic signed [31:0] mean_reg, mean_next;

    logic               ov_reg, ov_next;
    logic               oaxis_reg, oaxis_next;
    logic signed [31:0] ocoord_reg, ocoord_next;
    logic               ook_reg, ook_next;
    logic [7:0]         ogood_reg, ogood_next;
    logic               neg_reg, neg_next;

    // shared divider: reciprocals and the final mean
    logic        dv_start;
    logic [63:0] dv_numer, dv_denom, dv_quot;
    logic        dv_done;
    logic [63:0] dsq;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    knn_divider #(.N_BITS(64), .D_BITS(64)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dv_start),
        .numer(dv_numer), .denom(dv_denom), .done(dv_done), .quot(dv_quot)
    );

    assign mul_a = item_reg.distance;
    assign mul_b = item_reg.distance;
    assign mul_p = 64'(mul_a) * 64'(mul_b);
    assign dsq   = mul_p;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= knn_pkg::BK_IDLE;
            wsum_reg  <= '0;
            wtot_reg  <= '0;
            psum_reg  <= '0;
            cnt_reg   <= '0;
            zseen_reg <= 1'b0;
            done_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            wsum_reg  <= wsum_next;
            wtot_reg  <= wtot_next;
            psum_reg  <= psum_next;
            cnt_reg   <= cnt_next;
            zseen_reg <= zseen_next;
            done_reg  <= done_next;
            ov_reg    <= ov_next;
        end
        item_reg   <= item_next;
        use_reg    <= use_next;
        val_reg    <= val_next;
        w_reg      <= w_next;
        prod_reg   <= prod_next;
        dsq_reg    <= dsq_next;
        mean_reg   <= mean_next;
        oaxis_reg  <= oaxis_next;
        ocoord_reg <= ocoord_next;
        ook_reg    <= ook_next;
        ogood_reg  <= ogood_next;
        neg_reg    <= neg_next;
    end

    logic [7:0]         limit;
    logic signed [63:0] sum_try;
    logic               weighted;
    logic signed [63:0] num_s, den_s;
    logic [63:0]        num_abs;
    logic signed [64:0] q_signed;
    logic [63:0]        sqmul;

    assign limit = (use_count == 8'd0) ? 8'd1 : use_count;
    assign sqmul = dsq;

    // d^2 divides 2^64 exactly only when d is a power of two
    function automatic logic sq_exact(input logic [31:0] d);
        return (d != '0) && ((d & (d - 32'd1)) == '0);
    endfunction

    always_comb begin
        state_next  = state_reg;
        item_next   = item_reg;
        wsum_next   = wsum_reg;
        wtot_next   = wtot_reg;
        psum_next   = psum_reg;
        cnt_next    = cnt_reg;
        zseen_next  = zseen_reg;
        done_next   = done_reg;
        use_next    = use_reg;
        val_next    = val_reg;
        w_next      = w_reg;
        prod_next   = prod_reg;
        dsq_next    = dsq_reg;
        mean_next   = mean_reg;
        ov_next     = ov_reg;
        oaxis_next  = oaxis_reg;
        ocoord_next = ocoord_reg;
        ook_next    = ook_reg;
        ogood_next  = ogood_reg;
        neg_next    = neg_reg;
        q_pop       = 1'b0;
        dv_start    = 1'b0;
        dv_numer    = 64'd0;
        dv_denom    = 64'd1;
        ram_rd_addr = q_addr;
        sum_try     = wsum_reg + prod_reg;
        weighted    = ((weight_mode == knn_pkg::WMODE_INV) ||
                       (weight_mode == knn_pkg::WMODE_INV_SQ)) && !zseen_reg;
        num_s       = 64'(psum_reg);
        den_s       = 64'(cnt_reg);
        if (weighted && wtot_reg != '0) begin
            num_s = wsum_reg;
            den_s = 64'(wtot_reg);
        end
        num_abs  = num_s[63] ? 64'(-num_s) : 64'(num_s);
        q_signed = neg_reg ? -$signed({1'b0, dv_quot}) : $signed({1'b0, dv_quot});

        if (ov_reg && m_ready) ov_next = 1'b0;

        case (state_reg)
            knn_pkg::BK_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    state_next = knn_pkg::BK_READ;
                end
            end
            knn_pkg::BK_READ: begin
                // table data is valid this cycle
                use_next = !done_reg && item_reg.good && !ram_rd_data[POSITION_BITS];
                val_next = 64'(signed'(ram_rd_data[POSITION_BITS-1:0]));
                dsq_next = item_reg.squared;
                state_next = knn_pkg::BK_RECIP;
            end
            knn_pkg::BK_RECIP: begin
                // 1/d = 2^40/d ; 1/d^2 = (2^64-1)/d^2 with exact-division fixup
                if (item_reg.zero_dist || (dsq_reg && item_reg.distance < 32'h1_0000)) begin
                    w_next     = 32'hFFFF_FFFF;
                    state_next = knn_pkg::BK_MUL;
                end else if (!dv_done) begin
                    dv_start = 1'b1;
                    dv_numer = dsq_reg ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h100_0000_0000;
                    dv_denom = dsq_reg ? sqmul : 64'(item_reg.distance);
                end else begin
                    w_next = (dv_quot[63:32] != '0) ? 32'hFFFF_FFFF : dv_quot[31:0];
                    // exact divisor of 2^64: quotient of (2^64-1) is one short
                    if (dsq_reg && dv_quot[63:32] == '0 && sq_exact(item_reg.distance)) begin
                        w_next = (dv_quot[31:0] == 32'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                 : dv_quot[31:0] + 32'd1;
                    end
                    state_next = knn_pkg::BK_MUL;
                end
            end
            knn_pkg::BK_MUL: begin
                prod_next  = val_reg * signed'(64'(w_reg));
                state_next = knn_pkg::BK_ACC;
            end
            knn_pkg::BK_ACC: begin
                if (use_reg) begin
                    if (item_reg.zero_dist) zseen_next = 1'b1;
                    psum_next = psum_reg + 48'(val_reg);
                    if (prod_reg > 0 && wsum_reg > S64MAX - prod_reg) wsum_next = S64MAX;
                    else if (prod_reg < 0 && wsum_reg < S64MIN - prod_reg) wsum_next = S64MIN;
                    else wsum_next = sum_try;
                    wtot_next = wtot_reg + 48'(w_reg);
                    cnt_next  = cnt_reg + 8'd1;
                    if (cnt_reg + 8'd1 >= limit) done_next = 1'b1;
                end
                if (!item_reg.last) begin
                    state_next = knn_pkg::BK_IDLE;
                end else begin
                    state_next = knn_pkg::BK_DIV;
                end
            end
            knn_pkg::BK_DIV: begin
                if (cnt_reg == '0) begin
                    mean_next  = '0;
                    state_next = knn_pkg::BK_OUT;
                end else if (!dv_done) begin
                    dv_start = 1'b1;
                    dv_numer = num_abs;
                    dv_denom = den_s;
                    neg_next = num_s[63];
                end else begin
                    if (q_signed > 65'sh0_7FFF_FFFF) mean_next = 32'sh7FFF_FFFF;
                    else if (q_signed < -65'sh0_8000_0000) mean_next = 32'sh8000_0000;
                    else mean_next = q_signed[31:0];
                    state_next = knn_pkg::BK_OUT;
                end
            end
            knn_pkg::BK_OUT: begin
                if (!ov_reg || m_ready) begin
                    ov_next     = 1'b1;
                    oaxis_next  = item_reg.axis;
                    ocoord_next = mean_reg;
                    ook_next    = (cnt_reg != '0);
                    ogood_next  = cnt_reg;
                    wsum_next   = '0;
                    wtot_next   = '0;
                    psum_next   = '0;
                    cnt_next    = '0;
                    zseen_next  = 1'b0;
                    done_next   = 1'b0;
                    state_next  = knn_pkg::BK_IDLE;
                end
            end
            default: state_next = knn_pkg::BK_IDLE;
        endcase
    end

    assign m_valid      = ov_reg;
    assign m_axis       = oaxis_reg;
    assign m_coordinate = ocoord_reg;
    assign m_ok         = ook_reg;
    assign m_good       = ogood_reg;
endmodule

// ----- rtl/knn_weighted_position_average.sv -----
// k-nearest-neighbour position average. load beats (mode 0) write one calibration
// coordinate and missing mark per axis and entry into a table memory; neighbour
// beats (mode 1) carry an entry and its distance, and the beat with tlast ends an
// event and produces one result beat. a front stage takes beats; a load beat is held
// until the neighbour queue is empty, so it never overtakes a queued neighbour, and
// then writes the table. neighbours go through a four-deep queue to a back sequencer
// that reads the table, forms a 1/d or 1/d^2 weight in a shared bit-serial divider and
// accumulates; the weight is formed in every weight mode. a neighbour passes through
// the read, reciprocal, multiply and accumulate states; the reciprocal skips the
// divider when the weight saturates (zero distance, or 1/d^2 with a distance below
// 2^16). the last neighbour adds the final mean division (skipped when no neighbour
// was good) and the load of the output register, which waits while an earlier result
// beat is still held. the divider yields one quotient bit per cycle. load beats are
// taken once the queue is empty. the table is not cleared; read only written entries.
module knn_weighted_position_average #(
    parameter int TABLE_DEPTH   = 4096,
    parameter int POSITION_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: axis[0], entry_index[12:1], position_value[44:13],
    // position_missing[45], neighbour_distance[77:46], zero fill up to 79
    input  logic [79:0] s_tdata,
    input  logic        s_tuser,   // mode
    input  logic        s_tlast,   // last_neighbour
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: result_axis[0], coordinate[32:1], reconstruction_ok[33],
    // good_neighbours[41:34], zero fill up to 47
    output logic [47:0] m_tdata,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    localparam int AW = $clog2(2*TABLE_DEPTH);
    localparam int QW = $bits(knn_pkg::nb_item_t) + AW;

    logic [1:0] weight_mode_reg;
    logic [7:0] use_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_mode_reg <= 2'd0;
            use_count_reg   <= 8'd10;
        end else if (cfg_we) begin
            case (cfg_index)
                knn_pkg::REG_WEIGHT_MODE: weight_mode_reg <= cfg_data[1:0];
                knn_pkg::REG_USE_COUNT:   use_count_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr, ram_raddr, fq_addr, bq_addr;
    logic [POSITION_BITS:0]  ram_wdata, ram_rdata;
    logic                    q_push, q_full, q_pop, q_empty;
    knn_pkg::nb_item_t       fq_item, bq_item;
    logic [QW-1:0]           q_out;

    knn_front #(.TABLE_DEPTH(TABLE_DEPTH), .POSITION_BITS(POSITION_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_tvalid), .s_ready(s_tready),
        .mode(s_tuser), .axis(s_tdata[0]), .entry_index(s_tdata[12:1]),
        .position_value(s_tdata[44:13]), .position_missing(s_tdata[45]),
        .neighbour_distance(s_tdata[77:46]), .last_neighbour(s_tlast),
        .weight_mode(weight_mode_reg),
        .ram_wr_en(ram_we), .ram_wr_addr(ram_waddr), .ram_wr_data(ram_wdata),
        .q_push(q_push), .q_item(fq_item), .q_addr(fq_addr), .q_full(q_full),
        .q_empty(q_empty)
    );

    // axis selects the upper half of the address space
    knn_ram #(.WIDTH(POSITION_BITS+1), .DEPTH(2**AW)) u_table (
        .aclk(aclk), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(ram_wdata),
        .rd_addr(ram_raddr), .rd_data(ram_rdata)
    );

    knn_queue #(.WIDTH(QW), .DEPTH(4)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .push_data({fq_item, fq_addr}), .full(q_full),
        .pop(q_pop), .empty(q_empty), .pop_data(q_out)
    );

    assign bq_item = q_out[QW-1:AW];
    assign bq_addr = q_out[AW-1:0];

    logic               o_axis, o_ok;
    logic signed [31:0] o_coord;
    logic [7:0]         o_good;

    knn_back #(.TABLE_DEPTH(TABLE_DEPTH), .POSITION_BITS(POSITION_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_empty(q_empty), .q_item(bq_item), .q_addr(bq_addr), .q_pop(q_pop),
        .ram_rd_addr(ram_raddr), .ram_rd_data(ram_rdata),
        .weight_mode(weight_mode_reg), .use_count(use_count_reg),
        .m_valid(m_tvalid), .m_ready(m_tready),
        .m_axis(o_axis), .m_coordinate(o_coord), .m_ok(o_ok), .m_good(o_good)
    );

    assign m_tdata = {6'd0, o_good, o_ok, o_coord, o_axis};
endmodule
